// ----- sv/mts_pkg.sv -----
// ----------------------------------------------------------------------------
// mts_pkg
// Shared constants, codes and types of the minimum tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int ENT_W       = DATA_W + 1;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_FILL
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic [DATA_W-1:0] minimum;
        logic [CNT_W-1:0]  entry_count;
        logic [1:0]        status;
    } t_result;

    typedef struct packed {
        logic              wr_en;
        logic [ENT_W-1:0]  wr_entry;
        logic              rd_en;
        logic              top_load;
        logic [CNT_W-1:0]  sp;
        logic [DATA_W-1:0] min;
    } t_update;

endpackage

// ----- sv/mts_ram.sv -----
// ----------------------------------------------------------------------------
// mts_ram
// Generic single-port-write, single-port-read memory with registered read.
// ----------------------------------------------------------------------------
module mts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/mts_alu.sv -----
// ----------------------------------------------------------------------------
// mts_alu
// Works out one operation from the pointer, the minimum and the top entry:
// the result transaction and the next stack state.
// ----------------------------------------------------------------------------
module mts_alu import mts_pkg::*; (
    input  logic [1:0]        i_operation,
    input  logic [DATA_W-1:0] i_push_value,
    input  logic [CNT_W-1:0]  i_sp,
    input  logic [DATA_W-1:0] i_min,
    input  logic [ENT_W-1:0]  i_top,
    output t_result           o_result,
    output t_update           o_update
);

    logic              empty;
    logic              full;
    logic              top_enc;
    logic [DATA_W-1:0] top_val;
    logic              push_low;
    logic [ENT_W:0]    enc_wide;
    logic [DATA_W-1:0] prev_min;
    logic [CNT_W-1:0]  sp_dec;

    assign empty    = (i_sp == '0);
    assign full     = (i_sp >= CNT_W'(STACK_DEPTH));
    assign top_enc  = ($signed(i_top) < $signed({i_min[DATA_W-1], i_min}))
                      || (!i_top[ENT_W-1] && i_top[DATA_W-1]);
    assign top_val  = top_enc ? i_min : i_top[DATA_W-1:0];
    assign push_low = $signed(i_push_value) < $signed(i_min);
    assign enc_wide = {i_push_value[DATA_W-1], i_push_value, 1'b0}
                      - {{2{i_min[DATA_W-1]}}, i_min};
    assign prev_min = {i_min[DATA_W-2:0], 1'b0} - i_top[DATA_W-1:0];
    assign sp_dec   = i_sp - CNT_W'(1);

    always_comb begin
        o_result          = '0;
        o_update          = '0;
        o_update.sp       = i_sp;
        o_update.min      = i_min;
        o_update.wr_entry = {i_push_value[DATA_W-1], i_push_value};
        case (i_operation)
            OP_PUSH: begin
                if (full) begin
                    o_result.result_value = top_val;
                    o_result.minimum      = i_min;
                    o_result.entry_count  = i_sp;
                    o_result.status       = ST_OVERFLOW;
                end else begin
                    o_update.wr_en    = 1'b1;
                    o_update.top_load = 1'b1;
                    o_update.sp       = i_sp + CNT_W'(1);
                    if (empty) begin
                        o_update.min = i_push_value;
                    end else if (push_low) begin
                        o_update.min      = i_push_value;
                        o_update.wr_entry = enc_wide[ENT_W-1:0];
                    end
                    o_result.result_value = i_push_value;
                    o_result.minimum      = o_update.min;
                    o_result.entry_count  = o_update.sp;
                    o_result.status       = ST_OK;
                end
            end
            OP_POP: begin
                if (empty) begin
                    o_result.status = ST_UNDERFLOW;
                end else begin
                    o_update.rd_en = (sp_dec != '0);
                    o_update.sp    = sp_dec;
                    if (top_enc) begin
                        o_update.min = prev_min;
                    end
                    o_result.result_value = top_val;
                    o_result.minimum      = (sp_dec == '0) ? '0 : o_update.min;
                    o_result.entry_count  = sp_dec;
                    o_result.status       = ST_OK;
                end
            end
            default: begin
                if (empty) begin
                    o_result.status = ST_UNDERFLOW;
                end else begin
                    o_result.result_value = top_val;
                    o_result.minimum      = i_min;
                    o_result.entry_count  = i_sp;
                    o_result.status       = ST_OK;
                end
            end
        endcase
    end

endmodule

// ----- sv/mts_out_reg.sv -----
// ----------------------------------------------------------------------------
// mts_out_reg
// Output register that holds a result transaction until it is taken.
// ----------------------------------------------------------------------------
module mts_out_reg import mts_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_valid,
    output logic    o_busy,
    output t_result o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign n_valid = i_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_busy   = r_valid && i_stall;
    assign o_result = r_result;

endmodule

// ----- sv/min_tracking_stack_top.sv -----
// ----------------------------------------------------------------------------
// min_tracking_stack_top
// Stack of signed 32-bit values that reports its running minimum. Entries
// below the minimum are stored encoded, so only one minimum register is kept.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      i_in_valid / o_in_stall   i_operation, i_push_value
//   out      output     o_out_valid / i_out_stall o_result_value, o_minimum,
//                                                 o_entry_count, o_status
//
// Push and query need no fill state. A pop that leaves entries passes through
// S_FILL with the input stalled, since the new top is read back from the stack
// memory, which has a registered read. The top entry is kept in a register.
// Reset empties the stack at once; the memory needs no clearing pass.
// A stalled result holds in the output register and stalls the input; the next
// transaction is accepted only while the register is free or being emptied.
// ----------------------------------------------------------------------------
module min_tracking_stack_top import mts_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_operation,
    input  logic signed [DATA_W-1:0] i_push_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_result_value,
    output logic signed [DATA_W-1:0] o_minimum,
    output logic [CNT_W-1:0]         o_entry_count,
    output logic [1:0]               o_status
);

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_sp;
    logic [DATA_W-1:0] r_min;
    logic [ENT_W-1:0]  r_top;
    logic [ENT_W-1:0]  n_top;
    logic [ENT_W-1:0]  rdata;
    logic [CNT_W-1:0]  rd_ptr;
    logic              accept;
    logic              out_busy;
    t_result           step_result;
    t_result           out_result;
    t_update           upd;

    assign o_in_stall = (r_state != S_IDLE) || out_busy;
    assign accept     = i_in_valid && !o_in_stall;
    assign rd_ptr     = r_sp - CNT_W'(2);

    mts_alu u_alu (
        .i_operation  (i_operation),
        .i_push_value (i_push_value),
        .i_sp         (r_sp),
        .i_min        (r_min),
        .i_top        (r_top),
        .o_result     (step_result),
        .o_update     (upd)
    );

    mts_ram #(
        .WIDTH (ENT_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && upd.wr_en),
        .i_waddr (r_sp[ADDR_W-1:0]),
        .i_wdata (upd.wr_entry),
        .i_raddr (rd_ptr[ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        n_top   = r_top;
        case (r_state)
            S_IDLE: begin
                if (accept && upd.rd_en) begin
                    n_state = S_FILL;
                end
                if (accept && upd.top_load) begin
                    n_top = upd.wr_entry;
                end
            end
            S_FILL: begin
                n_state = S_IDLE;
                n_top   = rdata;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
            r_min   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_sp  <= upd.sp;
                r_min <= upd.min;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
    end

    mts_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_result (step_result),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_busy   (out_busy),
        .o_result (out_result)
    );

    assign o_result_value = $signed(out_result.result_value);
    assign o_minimum      = $signed(out_result.minimum);
    assign o_entry_count  = out_result.entry_count;
    assign o_status       = out_result.status;

endmodule

// ----- sv/mts_checker.sv -----
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks of the minimum tracking stack, bound to the top level.
// ----------------------------------------------------------------------------
module mts_checker import mts_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic signed [DATA_W-1:0] o_result_value,
    input logic signed [DATA_W-1:0] o_minimum,
    input logic [CNT_W-1:0]         o_entry_count,
    input logic [1:0]               o_status
);

    // A refused push can only happen on a full stack.
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OVERFLOW)
        |-> (o_entry_count == CNT_W'(STACK_DEPTH)))
        else $error("overflow reported on a stack that is not full");

    // An underflow transaction reports an empty stack with zeroed values.
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_UNDERFLOW)
        |-> (o_entry_count == '0 && o_result_value == '0 && o_minimum == '0))
        else $error("underflow transaction with nonzero fields");

    // An empty stack has no minimum.
    a_empty_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_entry_count == '0) |-> (o_minimum == '0))
        else $error("minimum reported on an empty stack");

    // An accepted input transaction yields a result transaction in the next cycle.
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted transaction produced no result");

    // A stalled result transaction stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall)
        |=> (o_out_valid && $stable(o_result_value) && $stable(o_minimum)
             && $stable(o_entry_count) && $stable(o_status)))
        else $error("stalled result transaction changed");

endmodule

bind min_tracking_stack_top mts_checker u_mts_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_value (o_result_value),
    .o_minimum      (o_minimum),
    .o_entry_count  (o_entry_count),
    .o_status       (o_status)
);
